// ----- rtl/pcfl_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfl_pkg: shared types and codes for the per-channel flood limiter
// Item structs, table entry layout, action and kind codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfl_pkg;

    // input item kinds
    localparam logic [1:0] KIND_MSG    = 2'd0;
    localparam logic [1:0] KIND_DISC   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // result actions
    localparam logic [1:0] ACT_REATTACH = 2'd0;
    localparam logic [1:0] ACT_NONE     = 2'd1;
    localparam logic [1:0] ACT_DETACH   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SILENT = 2'd2;

    localparam logic [15:0] WINDOW_RST = 16'd2;
    localparam logic [15:0] LIMIT_RST  = 16'd5;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  channel;
        logic        chan_detached;
        logic [31:0] now_secs;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] result_channel;
        logic       notify;
        logic       last;
    } t_out_item;

    // one table entry, as held in a cell of the ring
    typedef struct packed {
        logic        valid;
        logic [31:0] start;
        logic [15:0] count;
        logic        mark;
    } t_entry;

    // per-step verdict from the head
    typedef struct packed {
        logic reattach;
        logic detach;
    } t_head_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/pcfl_cell.sv -----
// ----------------------------------------------------------------------------
// pcfl_cell: one table entry in the rotating ring
// Loads its neighbor's entry on every shift; valid bit clears on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfl_cell
    import pcfl_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_shift,
    input  t_entry i_d,
    output t_entry o_q
);

    logic        r_valid;
    logic [31:0] r_start;
    logic [15:0] r_count;
    logic        r_mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_d.valid;
        end
    end

    // payload needs no reset: only read behind a set valid bit
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_start <= i_d.start;
            r_count <= i_d.count;
            r_mark  <= i_d.mark;
        end
    end

    assign o_q = '{valid: r_valid, start: r_start, count: r_count, mark: r_mark};

endmodule

`default_nettype wire

// ----- rtl/pcfl_head.sv -----
// ----------------------------------------------------------------------------
// pcfl_head: entry update at the head of the ring
// Expiry check, reattach decision and own-channel count/detach update.
// ----------------------------------------------------------------------------
`default_nettype none

module pcfl_head
    import pcfl_pkg::*;
(
    input  t_in_item    i_item,
    input  wire         i_own,
    input  wire  [15:0] i_window,
    input  wire  [15:0] i_limit,
    input  t_entry      i_entry,
    output t_entry      o_entry,
    output t_head_res   o_res
);

    t_entry      w_e;
    t_head_res   w_res;
    logic [32:0] w_end;
    logic [15:0] w_inc;
    logic        w_expired;

    // window end formed one bit wider so it cannot wrap
    assign w_end     = {1'b0, i_entry.start} + 33'(i_window);
    assign w_expired = i_entry.valid && (w_end < {1'b0, i_item.now_secs});

    always_comb begin
        w_e   = i_entry;
        w_res = '0;
        w_inc = 16'd0;
        unique case (i_item.kind)
            KIND_DISC: begin
                w_e.valid = 1'b0;
            end
            KIND_STATUS: begin
                if (i_own) begin
                    w_e.mark = i_item.chan_detached;
                end
            end
            KIND_MSG: begin
                if (i_own) begin
                    w_e.mark = i_item.chan_detached;
                end
                if (w_expired) begin
                    if ((w_e.count >= i_limit) && w_e.mark) begin
                        w_res.reattach = 1'b1;
                        w_e.mark       = 1'b0;
                    end
                    w_e.valid = 1'b0;
                end
                if (i_own) begin
                    if (!w_e.valid) begin
                        if (!i_item.chan_detached) begin
                            w_e.valid = 1'b1;
                            w_e.start = i_item.now_secs;
                            w_e.count = 16'd1;
                        end
                    end else if (w_e.count >= i_limit) begin
                        // already over: restart window, keep counting
                        w_e.start = i_item.now_secs;
                        if (w_e.count != COUNT_MAX) begin
                            w_e.count = w_e.count + 16'd1;
                        end
                    end else begin
                        w_inc     = (w_e.count != COUNT_MAX) ? w_e.count + 16'd1 : w_e.count;
                        w_e.count = w_inc;
                        if (w_inc >= i_limit) begin
                            w_e.start    = i_item.now_secs;
                            w_e.mark     = 1'b1;
                            w_res.detach = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = w_e;
    assign o_res   = w_res;

endmodule

`default_nettype wire

// ----- rtl/per_channel_flood_limiter_unit.sv -----
// An accepted item steps the ring through every entry, then loads its final result.
// A new item is taken only in idle, once the last final result has loaded; the ring of entry
//   cells rotates once per item, one entry through the head each cycle unless a reattach waits.
// A reattach or final result that finds the output register full holds until it drains.
// Reset (synchronous, active low) clears all entry valid bits and restores the
//   registers to window 2, limit 5, not silent.
// ----------------------------------------------------------------------------
// per_channel_flood_limiter_unit: fixed-window flood limiter, one entry per channel
// Table entries sit in a ring of cells. Each item rotates the ring once; for a
// message the entry at the head is checked for expiry (reattach) and, for its
// own channel, counted (detach). Reattach results stream out in channel order,
// then one final result closes the item.
// ----------------------------------------------------------------------------
`default_nettype none

module per_channel_flood_limiter_unit
    import pcfl_pkg::*;
#(
    parameter int CHANNELS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // item input
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // result output
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out_data,
    // register writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = (IDX_W > 5) ? IDX_W : 5;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

    // ---------------- configuration registers ----------------
    logic [15:0] r_window;
    logic [15:0] r_limit;
    logic        r_silent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_limit  <= LIMIT_RST;
            r_silent <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW: r_window <= i_cfg_data;
                REG_LIMIT:  r_limit  <= i_cfg_data;
                REG_SILENT: r_silent <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- control ----------------
    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [IDX_W-1:0] r_idx;
    logic             r_detach;

    logic      w_can_load;   // output register free or draining this cycle
    logic      w_step;       // ring advances by one entry
    logic      w_own;        // head entry belongs to the item's channel
    logic      w_in_xfer;
    t_head_res w_res;

    assign w_can_load = !o_out_valid || i_out_ready;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_own      = (CMP_W'(r_idx) == CMP_W'(r_item.channel));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:  if (w_step && (r_idx == IDX_LAST)) n_state = ST_FINAL;
            ST_FINAL: if (w_can_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        // a reattach needs the output register; a quiet step never waits
        w_step     = (r_state == ST_SCAN) && (w_can_load || !w_res.reattach);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item   <= i_in_data;
            r_idx    <= '0;
            r_detach <= 1'b0;
        end else if (w_step) begin
            r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            if (w_res.detach) begin
                r_detach <= 1'b1;
            end
        end
    end

    // ---------------- ring of entry cells ----------------
    t_entry w_q    [CHANNELS];
    t_entry w_head;

    pcfl_head u_head (
        .i_item   (r_item),
        .i_own    (w_own),
        .i_window (r_window),
        .i_limit  (r_limit),
        .i_entry  (w_q[0]),
        .o_entry  (w_head),
        .o_res    (w_res)
    );

    // cell 0 is the head; processed entry re-enters at the tail
    for (genvar k = 0; k < CHANNELS; k++) begin : g_ring
        t_entry w_d;
        if (k == CHANNELS - 1) begin : g_tail
            assign w_d = w_head;
        end else begin : g_mid
            assign w_d = w_q[k+1];
        end
        pcfl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_step),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    // ---------------- output register ----------------
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      w_load_re;
    logic      w_load_fin;

    assign w_load_re  = w_step && w_res.reattach;
    assign w_load_fin = (r_state == ST_FINAL) && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_re || w_load_fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_re) begin
            r_out_data.action         <= ACT_REATTACH;
            r_out_data.result_channel <= 5'(r_idx);
            r_out_data.notify         <= !r_silent;
            r_out_data.last           <= 1'b0;
        end else if (w_load_fin) begin
            r_out_data.action         <= r_detach ? ACT_DETACH : ACT_NONE;
            r_out_data.result_channel <= r_item.channel;
            r_out_data.notify         <= r_detach && !r_silent;
            r_out_data.last           <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // a new item always starts the rotation at entry 0
    a_scan_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("scan did not start at entry 0");

    // the last entry step ends the rotation
    a_scan_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && w_step && (r_idx == IDX_LAST)) |=> (r_state == ST_FINAL))
        else $error("rotation did not close after last entry");

    // only reattach results come before the final one
    a_mid_reattach : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> (o_out_data.action == ACT_REATTACH))
        else $error("non-final result is not a reattach");

    // no ring movement outside a scan
    a_step_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (r_state == ST_SCAN) && !w_in_xfer)
        else $error("ring shifted outside scan");
`endif

endmodule

`default_nettype wire

// ----- test/per_channel_flood_limiter_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_flood_limiter_unit_test: self-checking bench for the flood limiter
// A directed table walks the corner cases of windowing, detach and reattach.
// Several register settings of random traffic follow. Every result transfer
// is checked field by field against an in-bench model of the channel table.
// ----------------------------------------------------------------------------

module per_channel_flood_limiter_unit_test;
    import pcfl_pkg::*;

    localparam int CHANNELS = 32;
    localparam logic [1:0] KIND_UNUSED = 2'd3;  // no code in the package; block ignores it
    localparam int PHASE_ITEMS = 75;
    localparam int HOLD_CYCLES = 400;

    // one line of the directed table: either a register setting or an item,
    // the latter optionally with its final result typed in by hand
    typedef struct packed {
        logic        is_cfg;
        logic [15:0] win;
        logic [15:0] lim;
        logic        quiet;
        t_in_item    item;
        logic        typed;
        t_out_item   res;
    } t_plan_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_WINDOW;
    logic [15:0] cfg_data = '0;

    per_channel_flood_limiter_unit #(.CHANNELS(CHANNELS)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Channel table model: our own copy of the entries and registers.
    // ------------------------------------------------------------------------
    logic        tbl_valid [CHANNELS];
    logic [31:0] tbl_start [CHANNELS];
    logic [15:0] tbl_count [CHANNELS];
    logic        tbl_mark  [CHANNELS];
    logic [15:0] win_len = WINDOW_RST;
    logic [15:0] msg_limit = LIMIT_RST;
    logic        quiet = 1'b0;

    t_out_item awaited_actions [$];   // results still owed by the block, oldest first

    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_detach = 0;
    int  n_reattach = 0;
    int  n_settings = 0;
    bit  valid_held = 0;              // in_valid as last scheduled by the sender
    int  burst_left = 0;

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_start[i] = '0;
            tbl_count[i] = '0;
            tbl_mark[i]  = 1'b0;
        end
    end

    function automatic t_out_item action_item(logic [1:0] act, logic [4:0] ch, logic fin);
        t_out_item r;
        r.action         = act;
        r.result_channel = ch;
        r.notify         = (act != ACT_NONE) && !quiet;
        r.last           = fin;
        return r;
    endfunction

    // One input item: expiry scan (message only), own-entry update, then the
    // closing result. Reattaches come out in channel order ahead of it.
    task automatic predict_flood_step(input t_in_item it);
        logic [32:0] deadline;
        logic [1:0]  fin;
        logic [4:0]  ch;
        ch  = it.channel;
        fin = ACT_NONE;
        case (it.kind)
            KIND_DISC: begin
                for (int i = 0; i < CHANNELS; i++) tbl_valid[i] = 1'b0;
            end
            KIND_STATUS: begin
                tbl_mark[ch] = it.chan_detached;
            end
            KIND_MSG: begin
                // status rides along with the message and is seen by the scan
                tbl_mark[ch] = it.chan_detached;
                for (int i = 0; i < CHANNELS; i++) begin
                    if (tbl_valid[i]) begin
                        // no wrap: start + window is formed on 33 bits
                        deadline = {1'b0, tbl_start[i]} + {17'b0, win_len};
                        if (deadline < {1'b0, it.now_secs}) begin
                            if (tbl_count[i] >= msg_limit && tbl_mark[i]) begin
                                awaited_actions.push_back(action_item(ACT_REATTACH, i[4:0], 1'b0));
                                tbl_mark[i] = 1'b0;
                            end
                            tbl_valid[i] = 1'b0;
                        end
                    end
                end
                if (!tbl_valid[ch]) begin
                    // a detached channel with no entry is not tracked
                    if (!it.chan_detached) begin
                        tbl_valid[ch] = 1'b1;
                        tbl_start[ch] = it.now_secs;
                        tbl_count[ch] = 16'd1;
                    end
                end else if (tbl_count[ch] >= msg_limit) begin
                    tbl_start[ch] = it.now_secs;
                    if (tbl_count[ch] != COUNT_MAX) tbl_count[ch]++;
                end else begin
                    if (tbl_count[ch] != COUNT_MAX) tbl_count[ch]++;
                    if (tbl_count[ch] >= msg_limit) begin
                        tbl_start[ch] = it.now_secs;
                        tbl_mark[ch]  = 1'b1;
                        fin = ACT_DETACH;
                    end
                end
            end
            default: ;
        endcase
        awaited_actions.push_back(action_item(fin, ch, 1'b1));
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one item and hold it until the transfer. Valid is left high so a
    // following item in the same burst goes out back to back.
    task automatic offer(input t_in_item it, input logic typed, input t_out_item res);
        int gap;
        in_valid <= 1'b1;
        in_data  <= it;
        valid_held = 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_items++;
        predict_flood_step(it);
        // a hand-typed final result takes the place of the predicted one
        if (typed) awaited_actions[awaited_actions.size() - 1] = res;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid <= 1'b0;
                valid_held = 0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every owed result is in before returning.
    task automatic settle_idle();
        if (valid_held) begin
            in_valid <= 1'b0;
            valid_held = 0;
        end
        while (awaited_actions.size() != 0) @(posedge clk);
        repeat (CHANNELS + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_WINDOW: win_len = val;
            REG_LIMIT:  msg_limit = val;
            REG_SILENT: quiet = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] w, input logic [15:0] l, input logic q);
        settle_idle();
        write_reg(REG_WINDOW, w);
        write_reg(REG_LIMIT, l);
        write_reg(REG_SILENT, {15'b0, q});
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // table row builders
    function automatic t_in_item mk_item(logic [1:0] k, logic [4:0] ch, logic det,
                                         logic [31:0] now);
        t_in_item it;
        it.kind = k;
        it.channel = ch;
        it.chan_detached = det;
        it.now_secs = now;
        return it;
    endfunction

    function automatic t_plan_row item_row(logic [1:0] k, logic [4:0] ch, logic det,
                                           logic [31:0] now);
        t_plan_row r;
        r = '0;
        r.item = mk_item(k, ch, det, now);
        return r;
    endfunction

    function automatic t_plan_row checked_row(logic [1:0] k, logic [4:0] ch, logic det,
                                              logic [31:0] now, logic [1:0] act, logic note);
        t_plan_row r;
        r = item_row(k, ch, det, now);
        r.typed = 1'b1;
        r.res.action = act;
        r.res.result_channel = ch;
        r.res.notify = note;
        r.res.last = 1'b1;
        return r;
    endfunction

    function automatic t_plan_row regs_row(logic [15:0] w, logic [15:0] l, logic q);
        t_plan_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.win = w;
        r.lim = l;
        r.quiet = q;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row   plan [$];
        t_plan_row   row;
        t_in_item    it;
        logic [31:0] now;
        logic [4:0]  hot [3];
        logic [15:0] set_w [6];
        logic [15:0] set_l [6];
        logic        set_q [6];
        int          pick;
        int          step;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset registers first: window 2, limit 5, not silent.
        // ch0 counts up to the limit and detaches on the fifth message.
        plan.push_back(checked_row(KIND_MSG,    5'd0,  1'b0, 32'd0, ACT_NONE, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd0,  1'b0, 32'd1));
        plan.push_back(item_row   (KIND_MSG,    5'd0,  1'b0, 32'd1));
        plan.push_back(item_row   (KIND_MSG,    5'd0,  1'b0, 32'd1));
        plan.push_back(checked_row(KIND_MSG,    5'd0,  1'b0, 32'd1, ACT_DETACH, 1'b1));
        plan.push_back(checked_row(KIND_STATUS, 5'd0,  1'b1, 32'd1, ACT_NONE, 1'b0));
        // window runs out: reattach of ch0 ahead of the ch31 result
        plan.push_back(item_row   (KIND_MSG,    5'd31, 1'b0, 32'd4));
        // detached and untracked: no entry is started
        plan.push_back(checked_row(KIND_MSG,    5'd5,  1'b1, 32'd4, ACT_NONE, 1'b0));
        plan.push_back(checked_row(KIND_UNUSED, 5'd7,  1'b1, 32'hFFFF_FFFF, ACT_NONE, 1'b0));
        plan.push_back(checked_row(KIND_DISC,   5'd31, 1'b0, 32'd4, ACT_NONE, 1'b0));
        // top of time: start + window must not wrap, so ch31 never expires here
        plan.push_back(checked_row(KIND_MSG,    5'd31, 1'b0, 32'hFFFF_FFFF, ACT_NONE, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd30, 1'b0, 32'd0));
        // zero window, limit of one, silent: first message never detaches
        plan.push_back(regs_row(16'd0, 16'd1, 1'b1));
        plan.push_back(item_row   (KIND_MSG,    5'd1,  1'b0, 32'd100));
        plan.push_back(item_row   (KIND_MSG,    5'd1,  1'b0, 32'd100));
        // zero limit
        plan.push_back(regs_row(16'd1, 16'd0, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd2,  1'b0, 32'd300));
        plan.push_back(item_row   (KIND_MSG,    5'd2,  1'b0, 32'd300));
        plan.push_back(item_row   (KIND_MSG,    5'd2,  1'b0, 32'd300));
        // widest window and highest limit; expiry exactly one past the edge
        plan.push_back(regs_row(16'hFFFF, 16'hFFFF, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd3,  1'b0, 32'd0));
        plan.push_back(item_row   (KIND_MSG,    5'd3,  1'b0, 32'd65535));
        plan.push_back(item_row   (KIND_MSG,    5'd3,  1'b0, 32'd65536));
        // full detach / reattach round trip with a short window
        plan.push_back(regs_row(16'd1, 16'd2, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd4,  1'b0, 32'd200));
        plan.push_back(item_row   (KIND_MSG,    5'd4,  1'b0, 32'd200));
        plan.push_back(checked_row(KIND_STATUS, 5'd4,  1'b1, 32'd200, ACT_NONE, 1'b0));
        plan.push_back(item_row   (KIND_MSG,    5'd9,  1'b0, 32'd202));

        foreach (plan[k]) begin
            row = plan[k];
            if (row.is_cfg) program_regs(row.win, row.lim, row.quiet);
            else offer(row.item, row.typed, row.res);
        end

        // Random part: several register settings, extremes among them.
        set_w = '{16'd2, 16'd1, 16'hFFFF, 16'd1, 16'd0, 16'($urandom_range(1, 6))};
        set_l = '{16'd5, 16'd3, 16'd3, 16'hFFFF, 16'd2, 16'($urandom_range(1, 6))};
        set_q = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1))};

        for (int ph = 0; ph < 6; ph++) begin
            program_regs(set_w[ph], set_l[ph], set_q[ph]);
            now = $urandom;
            // a few busy channels per setting so limits are actually reached
            for (int j = 0; j < 3; j++) hot[j] = 5'($urandom_range(0, CHANNELS - 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                step = $urandom_range(0, 99);
                if (step < 80)      now += $urandom_range(0, 1);
                else if (step < 92) now += $urandom_range(2, 4);
                else if (step < 97) now += {16'b0, win_len} + $urandom_range(1, 3);
                else                now = $urandom;

                pick = $urandom_range(0, 99);
                it.now_secs = now;
                it.channel = ($urandom_range(0, 9) < 8) ? hot[$urandom_range(0, 2)]
                                                         : 5'($urandom_range(0, CHANNELS - 1));
                // the user mostly reports the status the block has left it in
                it.chan_detached = ($urandom_range(0, 99) < 85) ? tbl_mark[it.channel]
                                                                : 1'($urandom_range(0, 1));
                if (pick < 3)       it.kind = KIND_DISC;
                else if (pick < 5)  it.kind = KIND_UNUSED;
                else if (pick < 15) it.kind = KIND_STATUS;
                else                it.kind = KIND_MSG;
                offer(it, 1'b0, '0);
            end
        end

        settle_idle();
        $display("tb: %0d items over %0d register settings, %0d results checked",
                 n_items, n_settings, n_results);
        $display("tb: %0d detaches, %0d reattaches seen, %0d mismatches",
                 n_detach, n_reattach, errors);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stretches of differing stall patterns, plus one long hold-off
    // once traffic is flowing so the block backs up into its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        bit hold_done;
        int mode;
        int len;
        int period;
        hold_done = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && n_items >= 150) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1;
            end
            mode   = $urandom_range(0, 3);
            len    = $urandom_range(1, 60);
            period = $urandom_range(2, 5);
            for (int c = 0; c < len; c++) begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((c % period) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string fname, input logic [4:0] want, input logic [4:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            n_results++;
            if (out_data.action == ACT_DETACH) n_detach++;
            if (out_data.action == ACT_REATTACH) n_reattach++;
            if (awaited_actions.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got %p", $time, out_data);
            end else begin
                want = awaited_actions.pop_front();
                check_field("action", {3'b0, want.action}, {3'b0, out_data.action});
                check_field("result_channel", want.result_channel, out_data.result_channel);
                check_field("notify", {4'b0, want.notify}, {4'b0, out_data.notify});
                check_field("last", {4'b0, want.last}, {4'b0, out_data.last});
            end
        end
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
